>>> rtl/avt_pkg.sv
// Package with the types, codes and helper functions of the address vote tally.
`timescale 1ns / 1ps
package avt_pkg;

    localparam int TABLE_SLOTS_DEF = 16;

    localparam logic [4:0] MAX_ADDR_BYTES = 5'd18;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_VOTE_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'd1;

    localparam logic [7:0] VOTE_LIMIT_RESET   = 8'd120;
    localparam logic [9:0] WINDOW_TICKS_RESET = 10'(10 * 60);

    localparam logic [1:0] CMD_OBSERVE = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;

    localparam logic [7:0] VOTES_MAX   = 8'd255;
    localparam logic [9:0] ELAPSED_MAX = 10'd1023;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] addr_hi;
        logic [63:0] addr_mid;
        logic [15:0] addr_lo;
        logic [4:0]  addr_len;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        decided;
        logic        has_winner;
        logic [63:0] winner_hi;
        logic [63:0] winner_mid;
        logic [15:0] winner_lo;
        logic [4:0]  winner_len;
        logic [7:0]  winner_votes;
    } out_t;

    typedef struct packed {
        logic        observe;
        logic        clear;
        logic        any_match;
        logic [4:0]  len;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [15:0] lo;
    } op_t;

    typedef struct packed {
        logic        any;
        logic [4:0]  len;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [15:0] lo;
        logic [7:0]  votes;
    } cand_t;

    // Keeps byte k of the word, counted from the top, when base + k lies below len.
    function automatic logic [63:0] keep_bytes64(logic [63:0] d, logic [4:0] len,
                                                 logic [4:0] base);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            if ({1'b0, len} > ({1'b0, base} + 6'(k))) begin
                r[63-8*k -: 8] = d[63-8*k -: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] keep_bytes16(logic [15:0] d, logic [4:0] len,
                                                 logic [4:0] base);
        logic [15:0] r;
        r = '0;
        for (int k = 0; k < 2; k++) begin
            if ({1'b0, len} > ({1'b0, base} + 6'(k))) begin
                r[15-8*k -: 8] = d[15-8*k -: 8];
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/avt_cell.sv
// One table cell: holds a slot and passes the running winner to its neighbor.
`timescale 1ns / 1ps
module avt_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           upd_en,
    input  avt_pkg::op_t   op,
    input  logic           prev_used,
    input  avt_pkg::cand_t prev_cand,
    output logic           used,
    output logic           match,
    output avt_pkg::cand_t cand
);

    logic           used_reg, used_next;
    logic [4:0]     len_reg, len_next;
    logic [63:0]    hi_reg, hi_next;
    logic [63:0]    mid_reg, mid_next;
    logic [15:0]    lo_reg, lo_next;
    logic [7:0]     votes_reg, votes_next;
    avt_pkg::cand_t cand_reg, cand_next;
    logic           insert;
    logic           take;

    assign match = used_reg && (len_reg == op.len) && (hi_reg == op.hi) &&
                   (mid_reg == op.mid) && (lo_reg == op.lo);
    assign insert = op.observe && !op.any_match && !used_reg && prev_used;

    always_comb begin
        used_next  = used_reg;
        len_next   = len_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        lo_next    = lo_reg;
        votes_next = votes_reg;
        if (upd_en) begin
            if (op.clear) begin
                used_next = 1'b0;
            end else if (insert) begin
                used_next  = 1'b1;
                len_next   = op.len;
                hi_next    = op.hi;
                mid_next   = op.mid;
                lo_next    = op.lo;
                votes_next = 8'd1;
            end else if (op.observe && match && (votes_reg != avt_pkg::VOTES_MAX)) begin
                votes_next = votes_reg + 8'd1;
            end
        end
    end

    // Strictly greater replaces, so the earliest cell keeps a tie.
    assign take = used_reg && (!prev_cand.any || (votes_reg > prev_cand.votes));

    always_comb begin
        if (take) begin
            cand_next = '{any: 1'b1, len: len_reg, hi: hi_reg, mid: mid_reg,
                          lo: lo_reg, votes: votes_reg};
        end else begin
            cand_next = prev_cand;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg   <= len_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        lo_reg    <= lo_next;
        votes_reg <= votes_next;
        cand_reg  <= cand_next;
    end

    assign used = used_reg;
    assign cand = cand_reg;

endmodule

>>> rtl/address_vote_tally.sv
// Top level of the address vote tally: a chain of table cells and its sequencer.
`timescale 1ns / 1ps
// Each accepted beat passes through ST_SCAN, while the winner search ripples
// through the cell chain one cell per clock, and then ST_DONE, which loads the
// registered result beat. A new beat is taken only once that result is loaded.
// A new beat is taken while the previous result still waits on m_ready.
// Reset (aresetn low, synchronous) empties the table, zeroes the total and the
// elapsed counter, and loads vote_limit 120 and window_ticks 600.
module address_vote_tally #(
    parameter int TABLE_SLOTS = avt_pkg::TABLE_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  avt_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output avt_pkg::out_t                 m_data,
    input  logic                          cfg_we,
    input  logic [avt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [avt_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       vote_limit_reg, vote_limit_next;
    logic [9:0]       window_ticks_reg, window_ticks_next;
    logic [7:0]       total_reg, total_next;
    logic [9:0]       elapsed_reg, elapsed_next;
    logic [1:0]       status_reg, status_next;
    logic             m_valid_reg, m_valid_next;
    avt_pkg::out_t    m_data_reg, m_data_next;

    logic             accept;
    logic             out_load;
    logic [4:0]       len_c;
    avt_pkg::op_t     op;
    logic             observe;
    logic             full;
    logic             any_match;

    logic [TABLE_SLOTS-1:0] used;
    logic [TABLE_SLOTS-1:0] match;
    logic [TABLE_SLOTS:0]   prev_used;
    avt_pkg::cand_t         cand [TABLE_SLOTS+1];

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign observe = (s_data.command == avt_pkg::CMD_OBSERVE);

    assign len_c = (s_data.addr_len > avt_pkg::MAX_ADDR_BYTES) ? avt_pkg::MAX_ADDR_BYTES
                                                               : s_data.addr_len;

    assign any_match = |match;
    assign full      = used[TABLE_SLOTS-1];

    always_comb begin
        op.observe   = observe;
        op.clear     = (s_data.command == avt_pkg::CMD_CLEAR);
        op.any_match = any_match;
        op.len       = len_c;
        op.hi        = avt_pkg::keep_bytes64(s_data.addr_hi, len_c, 5'd0);
        op.mid       = avt_pkg::keep_bytes64(s_data.addr_mid, len_c, 5'd8);
        op.lo        = avt_pkg::keep_bytes16(s_data.addr_lo, len_c, 5'd16);
    end

    assign prev_used[0] = 1'b1;
    assign cand[0]      = '0;

    for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
        avt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .upd_en    (accept),
            .op        (op),
            .prev_used (prev_used[i]),
            .prev_cand (cand[i]),
            .used      (used[i]),
            .match     (match[i]),
            .cand      (cand[i+1])
        );
        assign prev_used[i+1] = used[i];
    end

    always_comb begin
        vote_limit_next   = vote_limit_reg;
        window_ticks_next = window_ticks_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                avt_pkg::REG_VOTE_LIMIT:   vote_limit_next   = cfg_wdata[7:0];
                avt_pkg::REG_WINDOW_TICKS: window_ticks_next = cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        total_next   = total_reg;
        elapsed_next = elapsed_reg;
        status_next  = status_reg;
        if (accept) begin
            status_next = avt_pkg::STATUS_OK;
            unique case (s_data.command)
                avt_pkg::CMD_OBSERVE: begin
                    if (!any_match && full) begin
                        status_next = avt_pkg::STATUS_FULL;
                    end else if (total_reg != avt_pkg::VOTES_MAX) begin
                        total_next = total_reg + 8'd1;
                    end
                end
                avt_pkg::CMD_TICK: begin
                    if ((elapsed_reg < window_ticks_reg) &&
                        (elapsed_reg != avt_pkg::ELAPSED_MAX)) begin
                        elapsed_next = elapsed_reg + 10'd1;
                    end
                end
                avt_pkg::CMD_CLEAR: begin
                    total_next   = '0;
                    elapsed_next = '0;
                end
                default: ;
            endcase
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TABLE_SLOTS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next             = 1'b1;
            m_data_next.status       = status_reg;
            m_data_next.decided      = (total_reg >= vote_limit_reg) ||
                                       (elapsed_reg >= window_ticks_reg);
            m_data_next.has_winner   = cand[TABLE_SLOTS].any;
            m_data_next.winner_hi    = cand[TABLE_SLOTS].hi;
            m_data_next.winner_mid   = cand[TABLE_SLOTS].mid;
            m_data_next.winner_lo    = cand[TABLE_SLOTS].lo;
            m_data_next.winner_len   = cand[TABLE_SLOTS].len;
            m_data_next.winner_votes = cand[TABLE_SLOTS].votes;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            vote_limit_reg   <= avt_pkg::VOTE_LIMIT_RESET;
            window_ticks_reg <= avt_pkg::WINDOW_TICKS_RESET;
            total_reg        <= '0;
            elapsed_reg      <= '0;
            status_reg       <= avt_pkg::STATUS_OK;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            vote_limit_reg   <= vote_limit_next;
            window_ticks_reg <= window_ticks_next;
            total_reg        <= total_next;
            elapsed_reg      <= elapsed_next;
            status_reg       <= status_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/avt_checker.sv
// Port checker for the address vote tally and its bind to the top level.
`timescale 1ns / 1ps
module avt_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input avt_pkg::out_t m_data
);

    // A stalled result beat stays and keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // The block works on one beat at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again before the previous beat finished");

    // A full table implies at least one entry.
    a_full_has_winner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == avt_pkg::STATUS_FULL) |-> m_data.has_winner)
        else $error("table full reported with no entry");

    // An entry always holds at least one vote, and with no entry the winner length is zero.
    a_winner_votes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.has_winner == (m_data.winner_votes != 8'd0)))
        else $error("winner flag disagrees with winner votes");

    a_no_winner_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_winner |-> (m_data.winner_len == 5'd0))
        else $error("length reported without a winner");

endmodule

bind address_vote_tally avt_checker u_avt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
